### hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define PPT_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// overlapped implication
`define PPT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

	localparam int ADDR_BITS_DEF = 24;
	localparam int PAGE_BITS_DEF = 12;

	localparam int CMD_W  = 2;
	localparam int PERM_W = 7;
	localparam int FLAG_W = 8;

	localparam logic [FLAG_W-1:0] MAPPED_FLAG = 8'h80;

	typedef enum logic [CMD_W-1:0] {
		CMD_MAP     = 2'd0,
		CMD_PROTECT = 2'd1,
		CMD_UNMAP   = 2'd2,
		CMD_CHECK   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_RUN,
		ST_RESP
	} state_t;

	// result handed from the walker to the output register
	typedef struct packed {
		logic valid;
		logic ok;
	} result_t;

endpackage

`default_nettype wire

### hdl/page_permission_table.sv
`default_nettype none
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: address, size, permissions; tuser: command
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: ok
//
// an item goes through accept, range setup, one table read per page
// plus the last update, and the step that loads the result
// empty or out-of-range commands go from range setup straight to the result
// the single read port of the flag memory walks one page per cycle
// after reset the table is zeroed page by page with s_axis_tready low
// a result waiting on m_axis does not block the next accept; the walker waits
// only when it has a new result and the output word is still not taken

module page_permission_table
	import ppt_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// address, size, permissions from bit 0 up, zero padded to bytes
	input  wire logic [((2*ADDR_BITS+1+PERM_W)+7)/8*8-1:0] s_axis_tdata,
	// command
	input  wire logic [CMD_W-1:0]       s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// ok in bit 0, rest zero
	output logic [7:0]                  m_axis_tdata
);

	`include "assert_macros.svh"

	localparam int IDX_BITS = ADDR_BITS - PAGE_BITS;
	localparam int SIZE_LSB = ADDR_BITS;
	localparam int PERM_LSB = 2 * ADDR_BITS + 1;

	logic                 res_ready;
	result_t              res;

	logic                 mem_we;
	logic [IDX_BITS-1:0]  mem_waddr;
	logic [FLAG_W-1:0]    mem_wdata;
	logic                 mem_re;
	logic [IDX_BITS-1:0]  mem_raddr;
	logic [FLAG_W-1:0]    mem_rdata;

	logic                 out_valid_q;
	logic                 out_ok_q;

	ppt_walk #(
		.ADDR_BITS (ADDR_BITS),
		.PAGE_BITS (PAGE_BITS)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_addr   (s_axis_tdata[ADDR_BITS-1:0]),
		.in_size   (s_axis_tdata[SIZE_LSB+ADDR_BITS:SIZE_LSB]),
		.in_perm   (s_axis_tdata[PERM_LSB+PERM_W-1:PERM_LSB]),
		.res       (res),
		.res_ready (res_ready),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// one flag byte per page; reads and writes never hit the same page in one
	// cycle since the walk moves strictly upward
	ppt_mem #(
		.IDX_BITS (IDX_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output word register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_ok_q <= res.ok;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_ok_q};

	// one command in flight: no accept right after an accept
	`PPT_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word accepted while busy")
	// a result handed over shows up on the output
	`PPT_ASSERT_NXT(a_result_lands, clk, arst_n, res.valid && res_ready, m_axis_tvalid, "result lost on the way out")
	// the input stays closed while a result waits in the walker
	`PPT_ASSERT_IMP(a_no_accept_pending, clk, arst_n, res.valid, !s_axis_tready, "accept while result pending")
	// table is never written while idle
	`PPT_ASSERT(a_no_idle_write, clk, arst_n, !(s_axis_tready && mem_we), "table write while idle")

endmodule

`default_nettype wire

### hdl/ppt_mem.sv
`default_nettype none

module ppt_mem
	import ppt_pkg::*;
#(
	parameter int IDX_BITS = ADDR_BITS_DEF - PAGE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [IDX_BITS-1:0] waddr,
	input  wire logic [FLAG_W-1:0]   wdata,
	input  wire logic                re,
	input  wire logic [IDX_BITS-1:0] raddr,
	output logic      [FLAG_W-1:0]   rdata
);

	localparam int DEPTH = 1 << IDX_BITS;

	logic [FLAG_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/ppt_range.sv
`default_nettype none

module ppt_range
	import ppt_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic [ADDR_BITS-1:0]           addr,
	input  wire logic [ADDR_BITS:0]             size_m1,
	output logic                                ovf,
	output logic [ADDR_BITS-PAGE_BITS-1:0]      first_page,
	output logic [ADDR_BITS-PAGE_BITS-1:0]      last_page
);

	// address of the last byte, two spare bits so nothing wraps
	logic [ADDR_BITS+1:0] end_addr;

	assign end_addr   = {2'b00, addr} + {1'b0, size_m1};
	assign ovf        = |end_addr[ADDR_BITS+1:ADDR_BITS];
	assign first_page = addr[ADDR_BITS-1:PAGE_BITS];
	assign last_page  = end_addr[ADDR_BITS-1:PAGE_BITS];

endmodule

`default_nettype wire

### hdl/ppt_walk.sv
`default_nettype none

module ppt_walk
	import ppt_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [CMD_W-1:0]              in_cmd,
	input  wire logic [ADDR_BITS-1:0]          in_addr,
	input  wire logic [ADDR_BITS:0]            in_size,
	input  wire logic [PERM_W-1:0]             in_perm,
	output result_t                            res,
	input  wire logic                          res_ready,
	output logic                               mem_we,
	output logic [ADDR_BITS-PAGE_BITS-1:0]     mem_waddr,
	output logic [FLAG_W-1:0]                  mem_wdata,
	output logic                               mem_re,
	output logic [ADDR_BITS-PAGE_BITS-1:0]     mem_raddr,
	input  wire logic [FLAG_W-1:0]             mem_rdata
);

	localparam int IDX_BITS = ADDR_BITS - PAGE_BITS;

	state_t state_q, state_d;

	cmd_t                   cmd_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic [ADDR_BITS:0]     size_m1_q;
	logic                   empty_q;
	logic [PERM_W-1:0]      perm_q;
	logic                   ok_q;

	logic [IDX_BITS-1:0]    pg_q;
	logic [IDX_BITS-1:0]    last_q;
	logic                   issued_all_q;
	logic [IDX_BITS-1:0]    clr_q;

	logic                   rd_valid_s1;
	logic [IDX_BITS-1:0]    pg_s1;
	logic                   last_s1;

	logic                   ovf;
	logic [IDX_BITS-1:0]    first_page;
	logic [IDX_BITS-1:0]    last_page;

	logic                   accept;
	logic                   issue;
	logic                   fail;
	logic                   upd_done;
	logic [FLAG_W-1:0]      new_flags;

	ppt_range #(
		.ADDR_BITS (ADDR_BITS),
		.PAGE_BITS (PAGE_BITS)
	) u_range (
		.addr       (addr_q),
		.size_m1    (size_m1_q),
		.ovf        (ovf),
		.first_page (first_page),
		.last_page  (last_page)
	);

	assign accept = in_valid && in_ready;

	// page check and new entry value, in the cycle after the read
	assign fail = (state_q == ST_RUN) && rd_valid_s1 && (cmd_q == CMD_CHECK) &&
		(!mem_rdata[FLAG_W-1] || ((mem_rdata[PERM_W-1:0] & perm_q) != perm_q));
	assign upd_done = rd_valid_s1 && last_s1;
	assign issue = (state_q == ST_RUN) && !issued_all_q && !fail;

	always_comb begin
		case (cmd_q)
			CMD_MAP:     new_flags = mem_rdata | MAPPED_FLAG | {1'b0, perm_q};
			CMD_PROTECT: new_flags = MAPPED_FLAG | {1'b0, perm_q};
			default:     new_flags = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (empty_q || ovf) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (fail || upd_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		res.valid = 1'b0;
		res.ok    = ok_q;
		mem_we    = 1'b0;
		mem_waddr = pg_s1;
		mem_wdata = new_flags;
		mem_re    = issue;
		mem_raddr = pg_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_RUN: begin
				mem_we = rd_valid_s1 && (cmd_q != CMD_CHECK);
			end
			ST_RESP: begin
				res.valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			rd_valid_s1  <= 1'b0;
			issued_all_q <= 1'b0;
			ok_q         <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_CALC) begin
				issued_all_q <= 1'b0;
				ok_q         <= empty_q || !ovf;
			end else if (issue && (pg_q == last_q)) begin
				issued_all_q <= 1'b1;
			end
			if (fail) begin
				ok_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(in_cmd);
			addr_q    <= in_addr;
			size_m1_q <= in_size - 1'b1;
			empty_q   <= (in_size == '0);
			perm_q    <= in_perm;
		end
		if (state_q == ST_CALC) begin
			pg_q   <= first_page;
			last_q <= last_page;
		end else if (issue) begin
			pg_q <= pg_q + 1'b1;
		end
		pg_s1   <= pg_q;
		last_s1 <= (pg_q == last_q);
	end

endmodule

`default_nettype wire
